// ===== rtl/core/aes128_block_encrypt_defines.svh =====
// Assertion macros for the AES-128 encrypt block
`ifndef AES128_BLOCK_ENCRYPT_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_DEFINES_SVH
`ifndef SYNTH
`define AES_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("a");
`define AES_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("n");
`else
`define AES_ASSERT_IMPL(label, clk, rst, a, c)
`define AES_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== rtl/core/aes_pkg.sv =====
package aes_pkg;
  localparam int Rounds = 10;
  localparam int KeyWords = 4 * (Rounds + 1);
  localparam logic [1:0] RegKeyHigh = 2'd0;
  localparam logic [1:0] RegKeyLow = 2'd1;

  typedef logic [127:0] block_t;

  function automatic logic [7:0] sbox(input logic [7:0] b);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[b];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction
endpackage

// ===== rtl/core/aes_key_expand.sv =====
module aes_key_expand (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [1:0]            wr_index,
  input  logic [63:0]           wr_data,
  output aes_pkg::block_t       round_key [aes_pkg::Rounds + 1]
);
  function automatic aes_pkg::block_t next_key(input aes_pkg::block_t k, input logic [3:0] r);
    logic [31:0] t;
    logic [31:0] n0;
    logic [31:0] n1;
    logic [31:0] n2;
    logic [31:0] n3;
    t = aes_pkg::sub_word({k[23:0], k[31:24]}) ^ {aes_pkg::rcon(r), 24'h0};
    n0 = k[127:96] ^ t;
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // advance one schedule round per stage, in step with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      round_key[0] <= '0;
    end else if (wr_en) begin
      case (wr_index)
        aes_pkg::RegKeyHigh: round_key[0][127:64] <= wr_data;
        aes_pkg::RegKeyLow: round_key[0][63:0] <= wr_data;
        default: ;
      endcase
    end
    for (int r = 1; r <= aes_pkg::Rounds; r++) begin
      round_key[r] <= next_key(round_key[r-1], 4'(r));
    end
  end
endmodule

// ===== rtl/core/aes_round.sv =====
module aes_round (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  aes_pkg::block_t in_state,
  input  aes_pkg::block_t key,
  input  logic            last,
  output logic            out_valid,
  output aes_pkg::block_t out_state
);
  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  aes_pkg::block_t mixed;

  always_comb begin
    for (int n = 0; n < 16; n++) s[n] = in_state[127-8*n -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r+4*c] = aes_pkg::sbox(s[r + 4*((c+r)%4)]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        m[4*c+r] = t[4*c+r] ^ (t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3])
                   ^ aes_pkg::xtime(t[4*c+r] ^ t[4*c+((r+1)%4)]);
      end
    end
    for (int n = 0; n < 16; n++) mixed[127-8*n -: 8] = last ? t[n] : m[n];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_state <= mixed ^ key;
  end
endmodule

// ===== rtl/core/aes128_block_encrypt.sv =====
// AES-128 encryption pipeline.
// Write the key with cfg_we/cfg_index/cfg_data: index 0 is key_high, index 1
// key_low. A write applies to blocks sent from the next cycle on; the round
// keys follow it down the stages one round per cycle, so write only while
// no block is in flight.
// Raise start with block_high/block_low to send a block; busy is always low,
// so a block is taken every cycle. One full round sits in each of ten
// stages after a registered initial key add, so the ciphertext appears on
// cipher_high/cipher_low with done high from the last round register.
// Throughput is one block per cycle, set by the unrolled round stages.
// done lasts one cycle; the receiver cannot stall, so nothing is held back.
// Synchronous rst clears the valid bits and sets the key to all zeros.
`include "aes128_block_encrypt_defines.svh"
module aes128_block_encrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        done,
  output logic [63:0] cipher_high,
  output logic [63:0] cipher_low
);
  aes_pkg::block_t round_key [aes_pkg::Rounds + 1];
  aes_pkg::block_t st [aes_pkg::Rounds + 1];
  logic            vld [aes_pkg::Rounds + 1];

  assign busy = 1'b0;

  aes_key_expand u_key (
    .clk(clk), .rst(rst), .wr_en(cfg_we), .wr_index(cfg_index),
    .wr_data(cfg_data), .round_key(round_key)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start;
    end
    st[0] <= {block_high, block_low} ^ round_key[0];
  end

  for (genvar r = 1; r <= aes_pkg::Rounds; r++) begin : g_round
    aes_round u_round (
      .clk(clk), .rst(rst), .in_valid(vld[r-1]), .in_state(st[r-1]),
      .key(round_key[r]), .last(r == aes_pkg::Rounds),
      .out_valid(vld[r]), .out_state(st[r])
    );
  end

  assign done = vld[aes_pkg::Rounds];
  assign cipher_high = st[aes_pkg::Rounds][127:64];
  assign cipher_low = st[aes_pkg::Rounds][63:0];

  `AES_ASSERT_NEXT(a_first_stage, clk, rst, start, vld[0])
  `AES_ASSERT_NEXT(a_no_spur, clk, rst, !vld[aes_pkg::Rounds-1], !done)
  `AES_ASSERT_IMPL(a_never_busy, clk, rst, start, !busy)
endmodule
